### sv/ring_history_newest_match_lookup_unit_assert.svh
// Assertion macros shared by the ring history lookup modules.
`ifndef RING_HISTORY_NEWEST_MATCH_LOOKUP_UNIT_ASSERT_SVH
`define RING_HISTORY_NEWEST_MATCH_LOOKUP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// cause at this edge implies effect at this edge
`define RH_ASSERT_IMPLIES(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// cause at this edge implies effect at the next edge
`define RH_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

// condition must never hold
`define RH_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define RH_ASSERT_IMPLIES(label, clk, rst, cause, effect, msg)
`define RH_ASSERT_NEXT(label, clk, rst, cause, effect, msg)
`define RH_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### sv/rhnml_pkg.sv
// Types and constants shared by the ring history lookup modules.
package rhnml_pkg;

   localparam int POS_W     = 8;
   localparam int POS_EXT_W = 16;
   localparam int READING_W = 16;
   localparam int STAMP_W   = 32;

   localparam logic CMD_STORE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic store;
      logic lookup;
      logic scan;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
   } dp_status_type;

endpackage

### sv/rhnml_ctrl.sv
// Controller state machine: request intake, scan sequencing, response hand-off.
`include "ring_history_newest_match_lookup_unit_assert.svh"

module rhnml_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rhnml_pkg::dp_cmd_type    cmd,
   input  rhnml_pkg::dp_status_type status
);
   import rhnml_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_LOOKUP)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.store  = req_valid && (req_cmd == CMD_STORE);
            cmd.lookup = req_valid && (req_cmd == CMD_LOOKUP);
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RH_ASSERT_NEVER(a_load_over_held, clock, reset, cmd.load_rsp && rsp_valid_ff && rsp_stall, "response overwritten while stalled")
   `RH_ASSERT_NEXT(a_lookup_scans, clock, reset, req_valid && !req_stall && (req_cmd == CMD_LOOKUP), state_ff == ST_SCAN, "accepted lookup did not start a scan")
   `RH_ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && status.scan_done, state_ff == ST_DONE, "scan completion lost")
   `RH_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_rsp, rsp_valid_ff, "loaded response not presented")

endmodule

### sv/rhnml_datapath.sv
// Datapath: history memory, write pointer, fill count, newest-first scan and response registers.
`include "ring_history_newest_match_lookup_unit_assert.svh"

module rhnml_datapath #(
   parameter int HISTORY_DEPTH = 512,
   parameter int COORD_BITS    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rhnml_pkg::dp_cmd_type                cmd,
   output rhnml_pkg::dp_status_type             status,
   input  logic [rhnml_pkg::POS_W-1:0]          req_pos_x,
   input  logic [rhnml_pkg::POS_W-1:0]          req_pos_y,
   input  logic [rhnml_pkg::READING_W-1:0]      req_reading,
   input  logic [rhnml_pkg::STAMP_W-1:0]        req_stamp,
   output logic                                rsp_found,
   output logic [rhnml_pkg::READING_W-1:0]      rsp_match_reading,
   output logic [rhnml_pkg::STAMP_W-1:0]        rsp_match_stamp
);
   import rhnml_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int KW = 2 * COORD_BITS;
   localparam int EW = KW + READING_W + STAMP_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(HISTORY_DEPTH);

   logic [EW-1:0] mem [HISTORY_DEPTH];

   logic [AW-1:0]        wp_ff, wp_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [EW-1:0]        rd_data_ff;
   logic [KW-1:0]        key_ff, key_in;
   logic                 found_ff, found_in;
   logic [READING_W-1:0] reading_ff, reading_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic                 out_found_ff;
   logic [READING_W-1:0] out_reading_ff;
   logic [STAMP_W-1:0]   out_stamp_ff;

   logic [POS_EXT_W-1:0] x_ext, y_ext;
   logic [KW-1:0]        key_req;
   logic                 rd_en, hit;

   // coordinates truncated (or zero extended) to COORD_BITS
   assign x_ext   = POS_EXT_W'(req_pos_x);
   assign y_ext   = POS_EXT_W'(req_pos_y);
   assign key_req = {y_ext[COORD_BITS-1:0], x_ext[COORD_BITS-1:0]};

   assign rd_en = cmd.scan && (remain_ff != '0);
   assign hit   = pend_ff && (rd_data_ff[EW-1 -: KW] == key_ff);

   // last entry is compared in the same cycle that the count runs out
   assign status.hit       = hit;
   assign status.scan_done = hit || (remain_ff == '0);

   always_comb begin
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      remain_in  = remain_ff;
      pend_in    = pend_ff;
      rd_addr_in = rd_addr_ff;
      key_in     = key_ff;
      found_in   = found_ff;
      reading_in = reading_ff;
      stamp_in   = stamp_ff;
      if (cmd.store) begin
         wp_in = (wp_ff == LAST_IDX) ? '0 : wp_ff + AW'(1);
         if (fill_ff != FULL_CNT) fill_in = fill_ff + CW'(1);
      end
      if (cmd.lookup) begin
         // newest entry sits just behind the write pointer
         rd_addr_in = (wp_ff == '0) ? LAST_IDX : wp_ff - AW'(1);
         remain_in  = fill_ff;
         pend_in    = 1'b0;
         key_in     = key_req;
         found_in   = 1'b0;
         reading_in = '0;
         stamp_in   = '0;
      end
      if (cmd.scan) begin
         pend_in = rd_en;
         if (rd_en) begin
            rd_addr_in = (rd_addr_ff == '0) ? LAST_IDX : rd_addr_ff - AW'(1);
            remain_in  = remain_ff - CW'(1);
         end
         if (hit) begin
            found_in   = 1'b1;
            reading_in = rd_data_ff[READING_W+STAMP_W-1 -: READING_W];
            stamp_in   = rd_data_ff[STAMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wp_ff] <= {key_req, req_reading, req_stamp};
      if (rd_en) rd_data_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         fill_ff   <= '0;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      key_ff     <= key_in;
      found_ff   <= found_in;
      reading_ff <= reading_in;
      stamp_ff   <= stamp_in;
      if (cmd.load_rsp) begin
         out_found_ff   <= found_ff;
         out_reading_ff <= reading_ff;
         out_stamp_ff   <= stamp_ff;
      end
   end

   assign rsp_found         = out_found_ff;
   assign rsp_match_reading = out_reading_ff;
   assign rsp_match_stamp   = out_stamp_ff;

   `RH_ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > FULL_CNT, "fill count past depth")
   `RH_ASSERT_NEVER(a_wp_range, clock, reset, wp_ff > LAST_IDX, "write pointer past last slot")
   `RH_ASSERT_NEVER(a_remain_le_fill, clock, reset, remain_ff > fill_ff, "scan would visit unwritten slots")
   `RH_ASSERT_NEXT(a_fill_grows, clock, reset, cmd.store && (fill_ff != FULL_CNT), fill_ff == $past(fill_ff) + CW'(1), "store did not grow fill count")

endmodule

### sv/ring_history_newest_match_lookup_unit.sv
// Top level of the ring history newest-match lookup unit.
//
//   channel  dir  ports                                             handshake
//   req      in   req_cmd req_pos_x req_pos_y req_reading req_stamp req_valid / req_stall
//   rsp      out  rsp_found rsp_match_reading rsp_match_stamp        rsp_valid / rsp_stall
//
// A store request is taken without a stall; the next request may follow at once.
// A lookup holds req_stall while it scans the stored entries (at most
// HISTORY_DEPTH) newest first, ending early on a hit, until its result is loaded;
// the scan reads one entry a cycle through the single read port of the history memory.
// The response sits in an output register; stores and the next lookup's scan
// proceed while it waits, and a finished scan waits only if it is still held.
// Synchronous reset empties the history at once (fill count to zero).
module ring_history_newest_match_lookup_unit #(
   parameter int HISTORY_DEPTH = 512,
   parameter int COORD_BITS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [rhnml_pkg::POS_W-1:0]     req_pos_x,
   input  logic [rhnml_pkg::POS_W-1:0]     req_pos_y,
   input  logic [rhnml_pkg::READING_W-1:0] req_reading,
   input  logic [rhnml_pkg::STAMP_W-1:0]   req_stamp,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [rhnml_pkg::READING_W-1:0] rsp_match_reading,
   output logic [rhnml_pkg::STAMP_W-1:0]   rsp_match_stamp
);
   import rhnml_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rhnml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rhnml_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COORD_BITS    (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_reading       (req_reading),
      .req_stamp         (req_stamp),
      .rsp_found         (rsp_found),
      .rsp_match_reading (rsp_match_reading),
      .rsp_match_stamp   (rsp_match_stamp)
   );

endmodule

### test/ring_history_newest_match_lookup_unit_tb.sv
// Self-checking testbench for the ring history newest-match lookup unit.
`timescale 1ns / 1ps

module ring_history_newest_match_lookup_unit_tb;
   import rhnml_pkg::*;

   localparam int HIST_DEPTH    = 512;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_CYCLES  = HIST_DEPTH + 8;
   localparam int RANDOM_ITEMS  = 640;
   localparam int FILL_ITEMS    = 540;
   localparam int DIRECTED_ROWS = 21;

   typedef struct packed {
      logic                 found;
      logic [READING_W-1:0] reading;
      logic [STAMP_W-1:0]   stamp;
   } lookup_result_type;

   typedef struct packed {
      logic                 cmd;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
      logic [READING_W-1:0] reading;
      logic [STAMP_W-1:0]   stamp;
      logic                 typed;
      logic                 found;
      logic [READING_W-1:0] exp_reading;
      logic [STAMP_W-1:0]   exp_stamp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic [POS_W-1:0]     req_pos_x;
   logic [POS_W-1:0]     req_pos_y;
   logic [READING_W-1:0] req_reading;
   logic [STAMP_W-1:0]   req_stamp;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_found;
   logic [READING_W-1:0] rsp_match_reading;
   logic [STAMP_W-1:0]   rsp_match_stamp;

   // local copy of the history
   logic                 hist_valid   [HIST_DEPTH];
   logic [POS_W-1:0]     hist_x       [HIST_DEPTH];
   logic [POS_W-1:0]     hist_y       [HIST_DEPTH];
   logic [READING_W-1:0] hist_reading [HIST_DEPTH];
   logic [STAMP_W-1:0]   hist_stamp   [HIST_DEPTH];
   int unsigned          hist_wr_ptr;

   lookup_result_type expected_lookups [$];
   lookup_result_type oldest_lookup;
   stim_row_type      directed_rows [DIRECTED_ROWS];

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  rsp_hold_left = 0;
   bit  rsp_calm      = 1'b0;
   bit  sender_calm   = 1'b0;

   ring_history_newest_match_lookup_unit #(
      .HISTORY_DEPTH(HIST_DEPTH),
      .COORD_BITS   (POS_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_reading      (req_reading),
      .req_stamp        (req_stamp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_reading(rsp_match_reading),
      .rsp_match_stamp  (rsp_match_stamp)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** ring_history_newest_match_lookup_unit: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones; none at all while calm
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 15);
      if (r < 9)
         return 0;
      if (r < 14)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // pool of 16 points so stores and lookups collide often
   function automatic logic [POS_W-1:0] pick_coord();
      if ($urandom_range(0, 9) < 7)
         return POS_W'($urandom_range(0, 3) * 85);
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic lookup_result_type newest_match(input logic [POS_W-1:0] x,
                                                      input logic [POS_W-1:0] y);
      lookup_result_type r;
      int unsigned       slot;
      r    = '0;
      slot = hist_wr_ptr;
      for (int n = 0; n < HIST_DEPTH; n++) begin
         slot = (slot == 0) ? HIST_DEPTH - 1 : slot - 1;
         if (hist_valid[slot] && hist_x[slot] == x && hist_y[slot] == y) begin
            r.found   = 1'b1;
            r.reading = hist_reading[slot];
            r.stamp   = hist_stamp[slot];
            return r;
         end
      end
      return r;
   endfunction

   task automatic record_store(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic [READING_W-1:0] rd,
                               input logic [STAMP_W-1:0] st);
      hist_valid[hist_wr_ptr]   = 1'b1;
      hist_x[hist_wr_ptr]       = x;
      hist_y[hist_wr_ptr]       = y;
      hist_reading[hist_wr_ptr] = rd;
      hist_stamp[hist_wr_ptr]   = st;
      hist_wr_ptr = (hist_wr_ptr == HIST_DEPTH - 1) ? 0 : hist_wr_ptr + 1;
   endtask

   // Requests go in order, so the local history can be updated as each one is driven.
   task automatic send_request(input logic cmd, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [READING_W-1:0] rd,
                               input logic [STAMP_W-1:0] st, input logic typed,
                               input lookup_result_type typed_result);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_pos_x   <= x;
      req_pos_y   <= y;
      req_reading <= rd;
      req_stamp   <= st;
      if (cmd == CMD_LOOKUP)
         expected_lookups.push_back(typed ? typed_result : newest_match(x, y));
      else
         record_store(x, y, rd, st);
      do
         @(posedge clock);
      while (req_stall);
   endtask

   always @(posedge clock) begin
      if (rsp_hold_left == 0 && !rsp_calm && $urandom_range(0, 3) == 0)
         rsp_hold_left = pick_gap(1'b0);
      if ($urandom_range(0, 511) == 0)
         rsp_calm = !rsp_calm;
      rsp_stall <= (rsp_hold_left > 0);
      if (rsp_hold_left > 0)
         rsp_hold_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lookups.size() == 0) begin
            $error("response with no lookup pending: found=%0b reading=%h stamp=%h",
                   rsp_found, rsp_match_reading, rsp_match_stamp);
            error_count++;
         end else begin
            oldest_lookup = expected_lookups.pop_front();
            if (rsp_found !== oldest_lookup.found) begin
               $error("found: expected %0b, got %0b", oldest_lookup.found, rsp_found);
               error_count++;
            end
            if (rsp_match_reading !== oldest_lookup.reading) begin
               $error("match_reading: expected %h, got %h",
                      oldest_lookup.reading, rsp_match_reading);
               error_count++;
            end
            if (rsp_match_stamp !== oldest_lookup.stamp) begin
               $error("match_stamp: expected %h, got %h",
                      oldest_lookup.stamp, rsp_match_stamp);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic                 cmd;
      logic [POS_W-1:0]     x;
      logic [POS_W-1:0]     y;
      lookup_result_type    typed_result;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_STORE;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_reading = '0;
      req_stamp   = '0;
      hist_wr_ptr = 0;
      for (int i = 0; i < HIST_DEPTH; i++)
         hist_valid[i] = 1'b0;

      // cmd, x, y, reading, stamp, typed, found, exp reading, exp stamp
      directed_rows = '{
         '{CMD_LOOKUP,   0,   0, 16'hDEAD, 32'hCAFEF00D, 1, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP, 255, 255, 16'hFFFF, 32'hFFFFFFFF, 1, 0, 16'h0000, 32'h00000000},
         '{CMD_STORE,    0,   0, 16'h0000, 32'h00000000, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP,   0,   0, 16'hFFFF, 32'hFFFFFFFF, 1, 1, 16'h0000, 32'h00000000},
         '{CMD_STORE,  255, 255, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP, 255, 255, 16'h0000, 32'h00000000, 1, 1, 16'hFFFF, 32'hFFFFFFFF},
         '{CMD_LOOKUP,   0, 255, 16'h5A5A, 32'h12345678, 1, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP, 255,   0, 16'hA5A5, 32'h87654321, 1, 0, 16'h0000, 32'h00000000},
         '{CMD_STORE,    3,   4, 16'h1280, 32'd100,      0, 0, 16'h0000, 32'h00000000},
         '{CMD_STORE,    3,   4, 16'h1900, 32'd200,      0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP,   3,   4, 16'h0000, 32'h00000000, 1, 1, 16'h1900, 32'd200},
         '{CMD_STORE,  200,  17, 16'h8000, 32'h80000000, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP, 200,  17, 16'h0000, 32'h00000000, 1, 1, 16'h8000, 32'h80000000},
         '{CMD_STORE,    4,   3, 16'h0001, 32'h00000001, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP,   4,   3, 16'h0000, 32'h00000000, 1, 1, 16'h0001, 32'h00000001},
         '{CMD_LOOKUP,   3,   4, 16'h0000, 32'h00000000, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_STORE,    0,   0, 16'h7FFF, 32'h7FFFFFFF, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP,   0,   0, 16'h0000, 32'h00000000, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP, 128, 128, 16'h0000, 32'h00000000, 1, 0, 16'h0000, 32'h00000000},
         '{CMD_STORE,  170,  85, 16'h00FF, 32'h0000FFFF, 0, 0, 16'h0000, 32'h00000000},
         '{CMD_LOOKUP,  85, 170, 16'h0000, 32'h00000000, 0, 0, 16'h0000, 32'h00000000}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_result.found   = directed_rows[i].found;
         typed_result.reading = directed_rows[i].exp_reading;
         typed_result.stamp   = directed_rows[i].exp_stamp;
         send_request(directed_rows[i].cmd, directed_rows[i].pos_x, directed_rows[i].pos_y,
                      directed_rows[i].reading, directed_rows[i].stamp,
                      directed_rows[i].typed, typed_result);
      end

      // store-heavy fill wraps the ring, then a tail of evenly mixed stores and lookups probes it
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
         if (i < FILL_ITEMS)
            cmd = ($urandom_range(0, 15) != 0) ? CMD_STORE : CMD_LOOKUP;
         else
            cmd = ($urandom_range(0, 1) == 0) ? CMD_STORE : CMD_LOOKUP;
         x = pick_coord();
         y = pick_coord();
         if (cmd == CMD_LOOKUP && $urandom_range(0, 7) == 0) begin
            // early directed entry, overwritten once the ring wraps
            x = 8'd200;
            y = 8'd17;
         end
         send_request(cmd, x, y, READING_W'($urandom_range(0, 65535)), $urandom(),
                      1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_lookups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_lookups.size() == 0)
         $display("** ring_history_newest_match_lookup_unit: PASSED **");
      else
         $display("** ring_history_newest_match_lookup_unit: FAILED **");
      $finish;
   end

endmodule
